@@ src/mwms_pkg.sv @@
`timescale 1ns / 1ps

package mwms_pkg;

  localparam int MAX_MOTIF = 32;
  localparam int MAX_SEQ   = 1024;

  localparam int COL_W     = $clog2(MAX_MOTIF);
  localparam int CNT_W     = $clog2(MAX_SEQ + 2);
  localparam int LEN_W     = 6;
  localparam int BASE_W    = 3;
  localparam int WEIGHT_W  = 16;
  localparam int DELTA_W   = WEIGHT_W + 1;
  localparam int SCORE_W   = 21;
  localparam int THR_W     = 19;
  localparam int POS_W     = 10;
  localparam int CFG_IDX_W = 1;

  typedef logic [BASE_W-1:0]          base_t;
  typedef logic [COL_W-1:0]           col_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic signed [SCORE_W-1:0]  score_t;
  typedef logic signed [THR_W-1:0]    thr_t;

  localparam base_t BASE_OTHER    = 3'd4;
  localparam len_t  LEN_RESET     = 6'd8;
  localparam thr_t  THR_RESET     = 19'sd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTIF_LENGTH    = 1'b0,
    REG_SCORE_THRESHOLD = 1'b1
  } cfg_reg_t;

  // Broadcast control for the column cells.
  typedef struct packed {
    logic        shift;
    logic        base_ok;
    logic [1:0]  base;
    logic        load;
    logic [1:0]  ld_base;
    weight_t     ld_weight;
    delta_t      delta;
  } cell_ctl_t;

  // Last column index of the window: length 0 acts as 1, long lengths clamp.
  function automatic col_t last_col(input len_t ml);
    if (ml == '0) begin
      return '0;
    end else if (ml > len_t'(MAX_MOTIF)) begin
      return col_t'(MAX_MOTIF - 1);
    end else begin
      return col_t'(ml - len_t'(1));
    end
  endfunction

endpackage

@@ src/motif_weight_matrix_scanner.sv @@
`timescale 1ns / 1ps
// A base word that scores a hit shows its result at out_valid in the cycle after accept.
// One word per cycle while in_ready, loads and bases alike; each cell adds at most once per word.
// A word is taken while a result waits, as long as out_ready takes that result in the same cycle.
// Reset (synchronous, active low): weights zero, history all "other", base count zero,
// motif length 8, score threshold 1024, no result pending.
module motif_weight_matrix_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  mwms_pkg::base_t                     in_base_code,
  input  logic [4:0]                          in_column,
  input  mwms_pkg::weight_t                   in_weight,
  input  logic                                in_first_base,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mwms_pkg::POS_W-1:0]          out_position,
  output mwms_pkg::score_t                    out_score,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mwms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwms_pkg::THR_W-1:0]          cfg_data
);
  import mwms_pkg::*;

  // Column cells form a systolic chain: cell c holds the weights of column c and
  // the partial score of the window whose column c is the newest base. On each
  // base every cell takes its left neighbor's sum and adds its own weight, so
  // cell len-1 holds the finished window score. A weight load patches every
  // partial sum whose column c base matches, keeping all sums exact.

  len_t   motif_len_r;
  thr_t   thr_r;
  base_t  hist_r   [MAX_MOTIF];
  base_t  hist_nxt [MAX_MOTIF];
  cnt_t   seen_r;
  cnt_t   seen_nxt;
  cnt_t   seen_base;

  logic                 out_valid_r;
  logic [POS_W-1:0]     out_pos_r;
  score_t               out_score_r;

  logic      accept;
  logic      is_base;
  logic      is_load;
  logic      hit;
  col_t      len_m1;
  base_t     base_clamped;
  weight_t   old_sel;
  score_t    score_sel;
  cell_ctl_t ctl;

  score_t  psum_a     [MAX_MOTIF];
  score_t  psum_nxt_a [MAX_MOTIF];
  weight_t old_w_a    [MAX_MOTIF];
  base_t   corr_a     [MAX_MOTIF];
  logic    wr_en_a    [MAX_MOTIF];

  // Hold new words back only while a result sits unclaimed.
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_base   = accept && in_cmd;
  assign is_load   = accept && !in_cmd && (in_base_code < BASE_OTHER)
                     && ({1'b0, in_column} < (COL_W + 1)'(MAX_MOTIF));

  assign base_clamped = (in_base_code > BASE_OTHER) ? BASE_OTHER : in_base_code;
  assign len_m1       = last_col(motif_len_r);

  // Old weight of the loaded entry, for the correction delta.
  assign old_sel = old_w_a[col_t'(in_column)];

  always_comb begin
    ctl           = '0;
    ctl.shift     = is_base;
    ctl.base_ok   = base_clamped < BASE_OTHER;
    ctl.base      = base_clamped[1:0];
    ctl.load      = is_load;
    ctl.ld_base   = in_base_code[1:0];
    ctl.ld_weight = in_weight;
    ctl.delta     = delta_t'(in_weight) - delta_t'(old_sel);
  end

  genvar k;
  generate
    for (k = 0; k < MAX_MOTIF; k++) begin : g_cell
      localparam col_t K = col_t'(k);
      score_t left_sum;

      if (k == 0) begin : g_head
        assign left_sum = '0;
      end else begin : g_body
        assign left_sum = psum_a[k-1];
      end

      // Base that sits in the loaded column of this cell's window.
      assign corr_a[k]  = (K >= col_t'(in_column)) ? hist_r[K - col_t'(in_column)] : BASE_OTHER;
      assign wr_en_a[k] = (col_t'(in_column) == K);

      mwms_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .wr_en      (wr_en_a[k]),
        .psum_in    (left_sum),
        .corr_base  (corr_a[k]),
        .psum_o     (psum_a[k]),
        .psum_nxt_o (psum_nxt_a[k]),
        .old_weight (old_w_a[k])
      );
    end
  endgenerate

  // Base history: newest at entry 0, cleared to "other" at a sequence start.
  always_comb begin
    hist_nxt[0] = base_clamped;
    for (int i = 1; i < MAX_MOTIF; i++) begin
      hist_nxt[i] = in_first_base ? BASE_OTHER : hist_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MOTIF; i++) begin
        hist_r[i] <= BASE_OTHER;
      end
    end else if (is_base) begin
      hist_r <= hist_nxt;
    end
  end

  // Base count saturates one past the longest sequence.
  always_comb begin
    seen_base = in_first_base ? cnt_t'(0) : seen_r;
    seen_nxt  = (seen_base <= cnt_t'(MAX_SEQ)) ? seen_base + cnt_t'(1) : seen_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (is_base) begin
      seen_r <= seen_nxt;
    end
  end

  // Score the window that ends on this base.
  assign score_sel = psum_nxt_a[len_m1];
  assign hit = is_base && (seen_nxt > cnt_t'(len_m1)) && (seen_nxt <= cnt_t'(MAX_SEQ))
               && (score_sel > score_t'(thr_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      out_pos_r   <= POS_W'(seen_nxt - cnt_t'(len_m1) - cnt_t'(1));
      out_score_r <= score_sel;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_score    = out_score_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motif_len_r <= LEN_RESET;
      thr_r       <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MOTIF_LENGTH:    motif_len_r <= cfg_data[LEN_W-1:0];
        REG_SCORE_THRESHOLD: thr_r       <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= cnt_t'(MAX_SEQ + 1))
    else $error("base count beyond saturation");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_cmd) |=>
      (out_valid == ($past(out_valid) && !$past(out_ready))))
    else $error("weight load changed the result register");

  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd && in_first_base) |=> (seen_r == cnt_t'(1)))
    else $error("first base did not restart the count");

  a_hit_needs_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && !out_ready)) |->
      $past(in_valid && in_ready && in_cmd))
    else $error("result raised without a base word");
`endif

endmodule

@@ src/mwms_cell.sv @@
`timescale 1ns / 1ps

module mwms_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  mwms_pkg::cell_ctl_t ctl,
  input  logic                wr_en,
  input  mwms_pkg::score_t    psum_in,
  input  mwms_pkg::base_t     corr_base,
  output mwms_pkg::score_t    psum_o,
  output mwms_pkg::score_t    psum_nxt_o,
  output mwms_pkg::weight_t   old_weight
);
  import mwms_pkg::*;

  weight_t weights_r [4];
  score_t  psum_r;
  score_t  psum_nxt;

  assign old_weight = weights_r[ctl.ld_base];

  // Take the left neighbor's partial sum on a base; patch our own on a weight change.
  always_comb begin
    psum_nxt = psum_r;
    if (ctl.shift) begin
      psum_nxt = psum_in + (ctl.base_ok ? score_t'(weights_r[ctl.base]) : score_t'(0));
    end else if (ctl.load && (corr_base == {1'b0, ctl.ld_base})) begin
      psum_nxt = psum_r + score_t'(ctl.delta);
    end
  end

  always_ff @(posedge clk) begin
    psum_r <= psum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 4; b++) begin
        weights_r[b] <= '0;
      end
    end else if (ctl.load && wr_en) begin
      weights_r[ctl.ld_base] <= ctl.ld_weight;
    end
  end

  assign psum_o     = psum_r;
  assign psum_nxt_o = psum_nxt;

endmodule
